// File: rtl/core/rau_pkg.sv
package rau_pkg;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_ADDINT = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_RED    = 3'd4,
        OP_EQ     = 3'd5,
        OP_LT     = 3'd6,
        OP_INV    = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
        logic signed [31:0] int_value;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               compare_true;
        logic [1:0]         status;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic combine;
        logic gcd_init;
        logic gcd_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic direct;
        logic gcd_done;
    } t_sts;

endpackage

// File: rtl/core/rau_datapath.sv
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 32
) (
    input  logic      i_clk,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_result
);

    localparam int          OB      = OPERAND_BITS;
    localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        PH_GCD,
        PH_QN,
        PH_QD,
        PH_END
    } t_phase;

    t_in_item           r_in;
    logic signed [63:0] an, ad, bn, bd, iv;
    logic [2:0]         op;

    logic [31:0] m_an, m_ad, m_bn, m_bd, m_iv;
    logic [31:0] mul_a1, mul_b1, mul_a2, mul_b2, mul_a3, mul_b3;
    logic        mul_s1, mul_s2, mul_s3;

    logic [63:0] r_p1, r_p2, r_p3;
    logic        r_s1, r_s2, r_s3;
    logic [63:0] r_x, r_y;
    logic        r_nneg, r_dneg;

    logic [63:0] r_ga, r_gb, r_dv, r_qt, r_rm, r_qnum;
    logic [6:0]  r_bit;
    t_phase      r_ph;
    logic [64:0] sub;
    logic [63:0] rm_next, qt_next;

    t_out_item   r_res;

    logic               zden, direct;
    logic signed [63:0] sp1, sp2;
    logic [63:0]        nm, dm;
    logic               neg;
    logic signed [63:0] dir_num, dir_den;
    logic               dir_cmp;
    logic [1:0]         dir_st;

    assign op = r_in.op;

    always_comb begin
        an = 64'(signed'(r_in.a_num[OB-1:0]));
        ad = 64'(signed'(r_in.a_den[OB-1:0]));
        bn = 64'(signed'(r_in.b_num[OB-1:0]));
        bd = 64'(signed'(r_in.b_den[OB-1:0]));
        iv = 64'(signed'(r_in.int_value[OB-1:0]));
    end

    // magnitudes of multiplier operands
    assign m_an = an[63] ? 32'(-an) : an[31:0];
    assign m_ad = ad[63] ? 32'(-ad) : ad[31:0];
    assign m_bn = bn[63] ? 32'(-bn) : bn[31:0];
    assign m_bd = bd[63] ? 32'(-bd) : bd[31:0];
    assign m_iv = iv[63] ? 32'(-iv) : iv[31:0];

    always_comb begin
        zden = (ad == 64'sd0);
        direct = 1'b1;
        case (op)
            OP_ADD, OP_MUL, OP_EQ, OP_LT: begin
                zden = zden || (bd == 64'sd0);
                direct = zden || op == OP_EQ || op == OP_LT;
            end
            OP_DIV: begin
                zden = zden || (bd == 64'sd0) || (bn == 64'sd0);
                direct = zden;
            end
            OP_RED: direct = zden;
            OP_INV: zden = zden || (an == 64'sd0);
            default: direct = 1'b1;
        endcase
    end

    // pick the three products for each op
    always_comb begin
        mul_a1 = '0;
        mul_b1 = '0;
        mul_s1 = 1'b0;
        mul_a2 = '0;
        mul_b2 = '0;
        mul_s2 = 1'b0;
        mul_a3 = '0;
        mul_b3 = '0;
        mul_s3 = 1'b0;
        case (op)
            OP_ADD: begin
                mul_a1 = m_an;
                mul_b1 = m_bd;
                mul_s1 = an[63] ^ bd[63];
                mul_a2 = m_bn;
                mul_b2 = m_ad;
                mul_s2 = bn[63] ^ ad[63];
                mul_a3 = m_ad;
                mul_b3 = m_bd;
                mul_s3 = ad[63] ^ bd[63];
            end
            OP_ADDINT: begin
                mul_a1 = m_iv;
                mul_b1 = m_ad;
                mul_s1 = iv[63] ^ ad[63];
            end
            OP_MUL: begin
                mul_a1 = m_an;
                mul_b1 = m_bn;
                mul_s1 = an[63] ^ bn[63];
                mul_a3 = m_ad;
                mul_b3 = m_bd;
                mul_s3 = ad[63] ^ bd[63];
            end
            OP_DIV: begin
                mul_a1 = m_an;
                mul_b1 = m_bd;
                mul_s1 = an[63] ^ bd[63];
                mul_a3 = m_ad;
                mul_b3 = m_bn;
                mul_s3 = ad[63] ^ bn[63];
            end
            OP_RED: begin
                mul_a1 = m_an;
                mul_b1 = 32'd1;
                mul_s1 = an[63];
                mul_a3 = m_ad;
                mul_b3 = 32'd1;
                mul_s3 = ad[63];
            end
            OP_EQ: begin
                mul_a1 = m_an;
                mul_b1 = m_bd;
                mul_s1 = an[63] ^ bd[63];
                mul_a2 = m_bn;
                mul_b2 = m_ad;
                mul_s2 = bn[63] ^ ad[63];
            end
            OP_LT: begin
                // pn*qd vs qn*pd with positive denominators
                mul_a1 = m_an;
                mul_b1 = m_bd;
                mul_s1 = an[63] ^ ad[63];
                mul_a2 = m_bn;
                mul_b2 = m_ad;
                mul_s2 = bn[63] ^ bd[63];
            end
            default: begin
                mul_a1 = '0;
            end
        endcase
    end

    assign o_sts.direct   = direct;
    assign o_sts.gcd_done = (r_ph == PH_END);

    assign sp1 = r_s1 ? -$signed(r_p1) : $signed(r_p1);
    assign sp2 = r_s2 ? -$signed(r_p2) : $signed(r_p2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.mul) begin
            r_p1 <= 64'(mul_a1) * 64'(mul_b1);
            r_s1 <= mul_s1;
            r_p2 <= 64'(mul_a2) * 64'(mul_b2);
            r_s2 <= mul_s2;
            r_p3 <= 64'(mul_a3) * 64'(mul_b3);
            r_s3 <= mul_s3;
        end
        if (i_cmd.combine) begin
            if (r_s1 == r_s2 || r_p1 == 64'd0 || r_p2 == 64'd0) begin
                r_x    <= r_p1 + r_p2;
                r_nneg <= (r_p1 != 64'd0) ? r_s1 : r_s2;
            end else if (r_p1 >= r_p2) begin
                r_x    <= r_p1 - r_p2;
                r_nneg <= r_s1;
            end else begin
                r_x    <= r_p2 - r_p1;
                r_nneg <= r_s2;
            end
            r_y    <= r_p3;
            r_dneg <= r_s3;
        end
    end

    // iterative Euclid gcd and quotient unit on one restoring divider
    assign sub     = {r_rm[63:0], r_qt[63]} - {1'b0, r_dv};
    assign rm_next = sub[64] ? {r_rm[62:0], r_qt[63]} : sub[63:0];
    assign qt_next = {r_qt[62:0], ~sub[64]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_ga  <= r_x;
            r_gb  <= r_y;
            r_ph  <= PH_GCD;
            r_bit <= 7'd0;
        end else if (i_cmd.gcd_step && r_ph != PH_END) begin
            if (r_bit == 7'd0) begin
                if (r_ph == PH_GCD && r_gb == 64'd0) begin
                    r_ph  <= PH_QN;
                    r_dv  <= r_ga;
                    r_qt  <= r_x;
                    r_rm  <= 64'd0;
                    r_bit <= 7'd64;
                end else if (r_ph == PH_GCD) begin
                    r_dv  <= r_gb;
                    r_qt  <= r_ga;
                    r_rm  <= 64'd0;
                    r_bit <= 7'd64;
                end else begin
                    r_ph <= PH_END;
                end
            end else if (r_bit == 7'd1 && r_ph == PH_QN) begin
                r_qnum <= qt_next;
                r_ph   <= PH_QD;
                r_qt   <= r_y;
                r_rm   <= 64'd0;
                r_bit  <= 7'd64;
            end else begin
                r_rm  <= rm_next;
                r_qt  <= qt_next;
                r_bit <= r_bit - 7'd1;
                if (r_bit == 7'd1) begin
                    if (r_ph == PH_GCD) begin
                        r_ga <= r_gb;
                        r_gb <= rm_next;
                    end else begin
                        r_ph <= PH_END;
                    end
                end
            end
        end
    end

    assign nm  = r_qnum;
    assign dm  = r_qt;
    assign neg = (nm != 64'd0) && (r_nneg != r_dneg);

    always_comb begin
        dir_num = 64'sd0;
        dir_den = 64'sd0;
        dir_cmp = 1'b0;
        dir_st  = ST_OK;
        if (zden) begin
            dir_st = ST_ZDEN;
        end else begin
            case (op)
                OP_ADDINT: begin
                    dir_num = sp1 + an;
                    dir_den = ad;
                end
                OP_INV: begin
                    dir_num = ad;
                    dir_den = an;
                end
                OP_EQ:   dir_cmp = (sp1 == sp2);
                OP_LT:   dir_cmp = (sp1 < sp2);
                default: dir_cmp = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (direct) begin
                r_res <= '{dir_num, dir_den, dir_cmp, dir_st};
            end else if (r_y == 64'd0) begin
                r_res <= '{64'sd0, 64'sd0, 1'b0, ST_ZDEN};
            end else if (dm[63] || (nm[63] && !(neg && nm == MIN_NEG))) begin
                r_res <= '{64'sd0, 64'sd0, 1'b0, ST_OVF};
            end else begin
                r_res <= '{neg ? -$signed(nm) : $signed(nm), $signed(dm), 1'b0, ST_OK};
            end
        end
    end

    assign o_result = r_res;

endmodule

// File: rtl/core/rau_ctrl.sv
module rau_ctrl
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_COMB,
        S_GINIT,
        S_GCD,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.combine  = (r_state == S_COMB);
        o_cmd.gcd_init = (r_state == S_GINIT);
        o_cmd.gcd_step = (r_state == S_GCD);
        o_cmd.finish   = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_MUL;
                S_MUL:  r_state <= S_COMB;
                S_COMB: r_state <= i_sts.direct ? S_FIN : S_GINIT;
                S_GINIT: r_state <= S_GCD;
                S_GCD:  if (i_sts.gcd_done) r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/rational_arithmetic_unit.sv
// channel | handshake        | payload
// input   | i_valid/o_stall  | i_item  (t_in_item)
// output  | o_valid/i_stall  | o_item  (t_out_item)
// Compare, add-integer, invert and error items go from combine to finish.
// Add, multiply, divide and reduce items run Euclid steps of a 64-step
// restoring divider, then two exact quotients, all on one divider.
// Reset clears the controller; one item is held at a time.
// o_stall stays high from acceptance until the result item is taken.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    rau_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_item)
    );

endmodule

// File: rtl/core/rau_checker.sv
module rau_checker
    import rau_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_in_stall)
        else $error("input open while result pending");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("accepted item not taken in");

    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_item.status == ST_OK || i_out_item.status == ST_ZDEN ||
                         i_out_item.status == ST_OVF))
        else $error("bad status");

endmodule

bind rational_arithmetic_unit rau_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_item  (o_item)
);
